// ----- src/imm_pkg.sv -----
// imm_pkg: shared types and constants of the integer matrix multiplier
// depends on nothing; imported by integer_matrix_multiply, imm_product_checker and testbench
package imm_pkg;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 3;
  localparam int DIM_CFG_W  = 4;
  localparam int CFG_IDX_W  = 2;

  // defaults of the top level parameters
  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W_DEF  = 32;

  // dimension registers come out of reset at 8
  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

endpackage

// ----- src/integer_matrix_multiply.sv -----
// integer_matrix_multiply: top level of the integer matrix multiplier
// depends on imm_pkg and imm_ram
//
//   channel   dir   handshake             payload
//   in_       in    in_valid / in_stall   in_action, in_row, in_col, in_element_value
//   out_      out   out_valid / out_stall out_row, out_col, out_product_value, out_last
//   cfg_      in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// a write request of A or B stores one element; a compute request is served by the
// single shared multiply-accumulate unit that walks the inner dimension one product
// per cycle behind the ram read and multiply registers, giving all-zero sums when
// k is zero and no results at all when m or n is zero.
// reset is synchronous and active low; the stores have no reset and no clearing pass.
// in_stall is high for the whole compute; a stalled result holds the sequencer.
module integer_matrix_multiply
  import imm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic [INDEX_W-1:0]         in_row,
  input  logic [INDEX_W-1:0]         in_col,
  input  logic signed [VALUE_W-1:0]  in_element_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [INDEX_W-1:0]         out_row,
  output logic [INDEX_W-1:0]         out_col,
  output logic signed [VALUE_W-1:0]  out_product_value,
  output logic                       out_last,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [DIM_CFG_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_CFG_W-1:0] rows_m_r, rows_m_nxt;
  logic [DIM_CFG_W-1:0] cols_n_r, cols_n_nxt;
  logic [DIM_CFG_W-1:0] inner_k_r, inner_k_nxt;

  logic [DIM_W-1:0] m_r, m_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] r_r, r_nxt, c_r, c_nxt, q_r, q_nxt;
  logic             rd_v_r, rd_v_nxt, prod_v_r, prod_v_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt, prod_r;

  logic                out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]  out_row_r, out_col_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_last_r;

  logic in_accept, cfg_accept, out_load, issue;
  logic last_col, last_row;
  logic [DIM_W-1:0] m_clamp, n_clamp, k_clamp;

  logic            wr_ok, wr_a, wr_b;
  logic [AW-1:0]   wr_addr, a_rd_addr, b_rd_addr;
  logic signed [ELEMENT_WIDTH-1:0] a_rd, b_rd;
  logic signed [VALUE_W-1:0]       a_ext, b_ext;

  // handshakes
  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // element writes, rows or columns beyond the store are dropped
  assign wr_ok   = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_a    = in_accept && wr_ok && (in_action == ACT_WRITE_A);
  assign wr_b    = in_accept && wr_ok && (in_action == ACT_WRITE_B);
  assign wr_addr = AW'(int'(in_row) * MAX_DIM + int'(in_col));

  // operand addresses for the current inner step
  assign a_rd_addr = AW'(int'(r_r) * MAX_DIM + int'(q_r));
  assign b_rd_addr = AW'(int'(q_r) * MAX_DIM + int'(c_r));

  imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_a_store (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_element_value[ELEMENT_WIDTH-1:0]),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd)
  );

  imm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_b_store (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_element_value[ELEMENT_WIDTH-1:0]),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd)
  );

  // sign extension of stored elements
  assign a_ext = VALUE_W'(a_rd);
  assign b_ext = VALUE_W'(b_rd);

  // dimensions above the store size saturate
  assign m_clamp = (int'(rows_m_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_m_r);
  assign n_clamp = (int'(cols_n_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_n_r);
  assign k_clamp = (int'(inner_k_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_k_r);

  assign issue    = (state_r == S_MAC) && (q_r < k_r);
  assign last_col = (c_r + DIM_W'(1)) == n_r;
  assign last_row = (r_r + DIM_W'(1)) == m_r;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // configuration registers
  always_comb begin
    rows_m_nxt  = rows_m_r;
    cols_n_nxt  = cols_n_r;
    inner_k_nxt = inner_k_r;
    if (cfg_accept) begin
      case (cfg_index)
        REG_ROWS_M:  rows_m_nxt  = cfg_data;
        REG_COLS_N:  cols_n_nxt  = cfg_data;
        REG_INNER_K: inner_k_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer over result elements and inner steps
  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    q_nxt      = q_r;
    rd_v_nxt   = issue;
    prod_v_nxt = rd_v_r;
    acc_nxt    = prod_v_r ? acc_r + prod_r : acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == ACT_COMPUTE) &&
            (m_clamp != '0) && (n_clamp != '0)) begin
          m_nxt     = m_clamp;
          n_nxt     = n_clamp;
          k_nxt     = k_clamp;
          r_nxt     = '0;
          c_nxt     = '0;
          q_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (issue) begin
          q_nxt = q_r + DIM_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          q_nxt   = '0;
          acc_nxt = '0;
          if (last_col) begin
            c_nxt = '0;
            if (last_row) begin
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = r_r + DIM_W'(1);
              state_nxt = S_MAC;
            end
          end else begin
            c_nxt     = c_r + DIM_W'(1);
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_m_r    <= DIM_RESET;
      cols_n_r    <= DIM_RESET;
      inner_k_r   <= DIM_RESET;
      m_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      q_r         <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_m_r    <= rows_m_nxt;
      cols_n_r    <= cols_n_nxt;
      inner_k_r   <= inner_k_nxt;
      m_r         <= m_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      q_r         <= q_nxt;
      rd_v_r      <= rd_v_nxt;
      prod_v_r    <= prod_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath: product, accumulator and result payload
  always_ff @(posedge clk) begin
    prod_r <= VALUE_W'(a_ext * b_ext);
    acc_r  <= acc_nxt;
    if (out_load) begin
      out_row_r   <= INDEX_W'(r_r);
      out_col_r   <= INDEX_W'(c_r);
      out_value_r <= acc_r;
      out_last_r  <= last_col && last_row;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = signed'(out_value_r);
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  // the multiply pipeline is empty whenever a result is taken or the block is idle
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!rd_v_r && !prod_v_r))
    else $error("result taken with products still in flight");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_v_r && !prod_v_r))
    else $error("products in flight while idle");

  // the inner step never runs past the inner dimension
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (q_r <= k_r))
    else $error("inner step past inner dimension");

  // the final element of a compute returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_col && last_row) |=> (state_r == S_IDLE && out_last))
    else $error("last result did not end the compute");
`endif

endmodule

// ----- src/imm_ram.sv -----
// imm_ram: generic single write port, single read port ram with registered read
// depends on nothing
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/imm_product_checker.sv -----
// imm_product_checker: watches the request, result and register channels of the
// matrix multiplier, predicts every product element and compares it with the block
// depends on imm_pkg
module imm_product_checker
  import imm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ACTION_W-1:0]       in_action,
  input  logic [INDEX_W-1:0]        in_row,
  input  logic [INDEX_W-1:0]        in_col,
  input  logic signed [VALUE_W-1:0] in_element_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [INDEX_W-1:0]        out_row,
  input  logic [INDEX_W-1:0]        out_col,
  input  logic signed [VALUE_W-1:0] out_product_value,
  input  logic                      out_last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_CFG_W-1:0]      cfg_data,
  output int                        pending,
  output int                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DIM = MAX_DIM_DEF;

  typedef struct packed {
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [VALUE_W-1:0] value;
    logic               last;
  } product_t;

  // predicted element stores and dimension registers
  logic [VALUE_W-1:0]   a_elems [STORE_DIM*STORE_DIM];
  logic [VALUE_W-1:0]   b_elems [STORE_DIM*STORE_DIM];
  logic [DIM_CFG_W-1:0] rows_cfg = DIM_RESET;
  logic [DIM_CFG_W-1:0] cols_cfg = DIM_RESET;
  logic [DIM_CFG_W-1:0] inner_cfg = DIM_RESET;

  product_t expected_products [$];
  int waiting = 0;
  int mismatches = 0;

  assign pending = waiting;
  assign fail_count = mismatches;

  // register values above the store size act as the store size
  function automatic int clamp_dim(logic [DIM_CFG_W-1:0] d);
    return (d > STORE_DIM) ? STORE_DIM : int'(d);
  endfunction

  always @(posedge clk) begin : watch
    product_t got;
    product_t want;
    logic [VALUE_W-1:0] acc;
    int m;
    int n;
    int k;
    if (!rst_n) begin
      rows_cfg = DIM_RESET;
      cols_cfg = DIM_RESET;
      inner_cfg = DIM_RESET;
      expected_products.delete();
    end else begin
      // each result retires the oldest expected element
      if (out_valid && !out_stall) begin
        got.row = out_row;
        got.col = out_col;
        got.value = out_product_value;
        got.last = out_last;
        if (expected_products.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: row %0d col %0d value %0d last %0b",
                     got.row, got.col, $signed(got.value), got.last);
        end else begin
          want = expected_products.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected row %0d col %0d value %0d last %0b",
                       want.row, want.col, $signed(want.value), want.last);
              $display("                 got row %0d col %0d value %0d last %0b",
                       got.row, got.col, $signed(got.value), got.last);
            end
          end
        end
      end

      // accepted requests: element loads or a full product pass
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_WRITE_A: a_elems[in_row*STORE_DIM + in_col] = in_element_value;
          ACT_WRITE_B: b_elems[in_row*STORE_DIM + in_col] = in_element_value;
          ACT_COMPUTE: begin
            m = clamp_dim(rows_cfg);
            n = clamp_dim(cols_cfg);
            k = clamp_dim(inner_cfg);
            for (int r = 0; r < m; r++) begin
              for (int c = 0; c < n; c++) begin
                acc = '0;
                // dot product wraps at 32 bits
                for (int q = 0; q < k; q++)
                  acc = acc + a_elems[r*STORE_DIM + q] * b_elems[q*STORE_DIM + c];
                want.row = INDEX_W'(r);
                want.col = INDEX_W'(c);
                want.value = acc;
                want.last = (r == m - 1) && (c == n - 1);
                expected_products.push_back(want);
              end
            end
          end
          default: ;
        endcase
      end

      // dimension register writes take effect after this edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_M:  rows_cfg = cfg_data;
          REG_COLS_N:  cols_cfg = cfg_data;
          REG_INNER_K: inner_cfg = cfg_data;
          default: ;
        endcase
      end
    end
    waiting = expected_products.size();
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives element loads, dimension settings and product requests into
// integer_matrix_multiply with random gaps and stalls; imm_product_checker judges results
// depends on imm_pkg, integer_matrix_multiply and imm_product_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imm_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 110;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES = 50;
  localparam int STORE_DIM = MAX_DIM_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [ACTION_W-1:0]       in_action;
  logic [INDEX_W-1:0]        in_row;
  logic [INDEX_W-1:0]        in_col;
  logic signed [VALUE_W-1:0] in_element_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [INDEX_W-1:0]        out_row;
  logic [INDEX_W-1:0]        out_col;
  logic signed [VALUE_W-1:0] out_product_value;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DIM_CFG_W-1:0]      cfg_data;
  int                        pending;
  int                        fail_count;

  // handshake outcomes seen at the last rising edge
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;

  // stimulus bookkeeping
  int send_idle_pct = 10;
  int recv_stall_pct = 81;
  int holds_asked = 0;
  int holds_done = 0;
  int requests_sent = 0;
  int dim_m = STORE_DIM;
  int dim_n = STORE_DIM;
  int dim_k = STORE_DIM;
  bit a_loaded [STORE_DIM*STORE_DIM];
  bit b_loaded [STORE_DIM*STORE_DIM];

  integer_matrix_multiply dut (.*);

  imm_product_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin : result_side
    int held;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  // mostly small dimensions, sometimes zero, sometimes at or above the store size
  function automatic int pick_dim();
    case ($urandom_range(19))
      0: return 0;
      1, 2: return $urandom_range(8, 15);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // one request, with random idle cycles ahead of it
  task automatic send_request(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] r,
                              logic [INDEX_W-1:0] c, logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_row <= r;
    in_col <= c;
    in_element_value <= v;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    if (act == ACT_WRITE_A) a_loaded[r*STORE_DIM + c] = 1'b1;
    if (act == ACT_WRITE_B) b_loaded[r*STORE_DIM + c] = 1'b1;
    if (act != ACT_UNUSED) requests_sent++;
  endtask

  task automatic send_compute();
    send_request(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
  endtask

  // leaves cfg_valid high; set_dims lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
  endtask

  task automatic set_dims(int m, int n, int k);
    write_reg(REG_ROWS_M, DIM_CFG_W'(m));
    write_reg(REG_COLS_N, DIM_CFG_W'(n));
    write_reg(REG_INNER_K, DIM_CFG_W'(k));
    cfg_valid <= 1'b0;
    dim_m = (m > STORE_DIM) ? STORE_DIM : m;
    dim_n = (n > STORE_DIM) ? STORE_DIM : n;
    dim_k = (k > STORE_DIM) ? STORE_DIM : k;
  endtask

  // block must be idle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // load every element the next product pass will read and that is still unwritten
  task automatic fill_missing();
    for (int r = 0; r < dim_m; r++)
      for (int q = 0; q < dim_k; q++)
        if (!a_loaded[r*STORE_DIM + q])
          send_request(ACT_WRITE_A, INDEX_W'(r), INDEX_W'(q), rand_value());
    for (int q = 0; q < dim_k; q++)
      for (int c = 0; c < dim_n; c++)
        if (!b_loaded[q*STORE_DIM + c])
          send_request(ACT_WRITE_B, INDEX_W'(q), INDEX_W'(c), rand_value());
  endtask

  initial begin : stimulus
    int random_start;
    int progress;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_WRITE_A;
    in_row = '0;
    in_col = '0;
    in_element_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS_M;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: 2x2 product with extreme element values
    set_dims(2, 2, 2);
    send_request(ACT_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    send_request(ACT_WRITE_A, 0, 1, 32'h8000_0000);
    send_request(ACT_WRITE_A, 1, 0, 32'hFFFF_FFFF);
    send_request(ACT_WRITE_A, 1, 1, 32'h0000_0000);
    send_request(ACT_WRITE_B, 0, 0, 32'hFFFF_FFFF);
    send_request(ACT_WRITE_B, 0, 1, 32'h7FFF_FFFF);
    send_request(ACT_WRITE_B, 1, 0, 32'h8000_0000);
    send_request(ACT_WRITE_B, 1, 1, 32'h0000_0001);
    // stored outside the configured dimensions, must not disturb the product
    send_request(ACT_WRITE_A, 7, 7, 32'h5A5A_5A5A);
    send_request(ACT_WRITE_B, 7, 7, 32'hA5A5_A5A5);
    // unused action code changes nothing
    send_request(ACT_UNUSED, 7, 7, 32'hFFFF_FFFF);
    // index and value fields are don't-care on compute
    send_request(ACT_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    send_request(ACT_COMPUTE, 0, 0, 32'h0000_0000);
    // empty inner dimension gives all-zero sums
    wait_idle();
    set_dims(2, 2, 0);
    send_compute();
    // zero rows or zero columns give no results at all
    wait_idle();
    set_dims(0, 2, 2);
    send_compute();
    wait_idle();
    set_dims(2, 0, 2);
    send_compute();
    wait_idle();
    set_dims(1, 2, 2);
    send_compute();

    // random: loads with random content, then a product pass
    random_start = requests_sent;
    progress = 0;
    while (progress < RANDOM_REQUESTS) begin
      if (progress < RANDOM_REQUESTS / 3) begin
        send_idle_pct = 10;
        recv_stall_pct = 81;
      end else if (progress < 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 81;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(2) == 0) begin
        wait_idle();
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end
      repeat ($urandom_range(4))
        send_request($urandom_range(1) ? ACT_WRITE_B : ACT_WRITE_A,
                     3'($urandom), 3'($urandom), rand_value());
      if ($urandom_range(9) == 0)
        send_request(ACT_UNUSED, 3'($urandom), 3'($urandom), $urandom);
      fill_missing();
      send_compute();
      progress = requests_sent - random_start;
    end

    // full 8x8 result with rows and columns above range, results held back for a while
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    set_dims(15, 15, 2);
    fill_missing();
    holds_asked++;
    send_compute();
    repeat (6)
      send_request($urandom_range(1) ? ACT_WRITE_B : ACT_WRITE_A,
                   3'($urandom), 3'($urandom), rand_value());
    send_compute();

    // drain and report
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/imm_pkg.sv
src/imm_ram.sv
src/integer_matrix_multiply.sv
tb/imm_product_checker.sv
tb/testbench.sv
